// ===== sv/ray_segment_nearest_hit_defines.svh =====
// Assertion helpers used by the RTL file rsnh_back.sv.
`ifndef RAY_SEGMENT_NEAREST_HIT_DEFINES_SVH
`define RAY_SEGMENT_NEAREST_HIT_DEFINES_SVH

// Same-cycle implication.
`define RSNH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RSNH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rsnh_pkg.sv =====
`default_nettype none
package rsnh_pkg;

    localparam int MAX_WALLS_DEF = 64;
    localparam int FRAC_BITS_DEF = 12;

    localparam int COORD_W  = 24;
    localparam int TRIG_W   = 16;
    localparam int CORDIC_W = 34;
    localparam int CORDIC_STEPS = 20;
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;
    localparam int DIFF_W  = 25;
    localparam int DEN_W   = 41;
    localparam int CROSS_W = 50;
    localparam int NUM_W   = 64;
    localparam int SQ_W    = 52;
    localparam int Q_DEPTH = 2;

    typedef enum logic {
        OP_STORE = 1'b0,
        OP_CAST  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CFG_PLAYER_X      = 2'd0,
        CFG_PLAYER_Y      = 2'd1,
        CFG_RENDER_RADIUS = 2'd2,
        CFG_WALL_COUNT    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_op                       op;
        logic [5:0]                slot;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [TRIG_W-1:0]  dir_c;
        logic signed [TRIG_W-1:0]  dir_s;
        logic                      upper;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        F_IDLE,
        F_ROT,
        F_PUSH
    } t_fstate;

    typedef enum logic [4:0] {
        B_IDLE,
        B_NEXT,
        B_READ,
        B_PROD,
        B_SUM,
        B_DTEST,
        B_DIVQ,
        B_MULC,
        B_STARTX,
        B_DIVX,
        B_STARTY,
        B_DIVY,
        B_POINT,
        B_CHECK,
        B_SQADD,
        B_SQRT,
        B_CMP,
        B_RESULT
    } t_bstate;

    // arctan(2^-i) in units of a 32-bit full turn
    function automatic logic [31:0] atan_step(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Q4.30 -> Q2.14, round half up, clamp to +-1.0
    function automatic logic signed [TRIG_W-1:0] round_clamp(
        input logic signed [CORDIC_W-1:0] v
    );
        logic signed [CORDIC_W-1:0] r;
        logic signed [TRIG_W-1:0]   o;
        r = (v + 34'sd32768) >>> 16;
        if (r > 34'sd16384) begin
            o = 16'sd16384;
        end else if (r < -34'sd16384) begin
            o = -16'sd16384;
        end else begin
            o = r[TRIG_W-1:0];
        end
        return o;
    endfunction

endpackage
`default_nettype wire

// ===== sv/rsnh_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle, floor semantics.
module rsnh_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [rsnh_pkg::NUM_W-1:0]   i_num,
    input  wire logic signed [rsnh_pkg::DEN_W-1:0]   i_den,
    output logic                                     o_busy,
    output logic                                     o_done,
    output logic signed [rsnh_pkg::NUM_W-1:0]        o_quot
);
    localparam int NW = rsnh_pkg::NUM_W;
    localparam int DW = rsnh_pkg::DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_dm;
    logic [DW-1:0] r_rem;
    logic          r_neg;

    logic [DW:0]   w_trial;
    logic          w_ge;
    logic [DW:0]   w_diff;

    assign w_trial = {r_rem, r_q[NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_dm};
    assign w_diff  = w_trial - {1'b0, r_dm};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_q   <= i_num[NW-1] ? (NW'(0) - i_num) : i_num;
            r_dm  <= i_den[DW-1] ? (DW'(0) - i_den) : i_den;
            r_rem <= '0;
            r_neg <= i_num[NW-1] ^ i_den[DW-1];
        end else if (r_busy) begin
            r_q   <= {r_q[NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    // negative quotient with a remainder rounds down: -q - 1 = ~q
    assign o_quot = $signed(r_neg ? ((r_rem != '0) ? ~r_q : (NW'(0) - r_q)) : r_q);

endmodule
`default_nettype wire

// ===== sv/rsnh_queue.sv =====
`default_nettype none
// Two-word job queue between front and back.
module rsnh_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire rsnh_pkg::t_job     i_job,
    input  wire logic               i_pop,
    output rsnh_pkg::t_job          o_job,
    output rsnh_pkg::t_q_status     o_status
);
    localparam int QD  = rsnh_pkg::Q_DEPTH;
    localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW = $clog2(QD + 1);

    rsnh_pkg::t_job r_mem [QD];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QAW'(QD - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QAW'(QD - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_job          = r_mem[r_rp];
    assign o_status.full  = (r_cnt == QCW'(QD));
    assign o_status.empty = (r_cnt == '0);

endmodule
`default_nettype wire

// ===== sv/rsnh_front.sv =====
`default_nettype none
// Front: takes items, makes the ray direction, queues jobs.
module rsnh_front (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_start,
    output logic                                        o_busy,
    input  wire logic                                   i_operation,
    input  wire logic [5:0]                             i_wall_slot,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0]    i_end_ax,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0]    i_end_ay,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0]    i_end_bx,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0]    i_end_by,
    input  wire logic [15:0]                            i_ray_angle,
    input  wire rsnh_pkg::t_q_status                    i_q_status,
    output logic                                        o_push,
    output rsnh_pkg::t_job                              o_job
);
    localparam int CWD = rsnh_pkg::CORDIC_W;
    localparam logic signed [rsnh_pkg::TRIG_W-1:0] T_POS = 16'sd16384;
    localparam logic signed [rsnh_pkg::TRIG_W-1:0] T_NEG = -16'sd16384;

    rsnh_pkg::t_fstate r_state, n_state;
    rsnh_pkg::t_job    r_job;
    logic signed [CWD-1:0] r_x, r_y, r_z;
    logic [4:0]        r_i;
    logic              r_flip;

    logic              w_accept, w_special, w_direct, w_flip;
    logic [31:0]       w_phase;
    rsnh_pkg::t_job    w_in_job, w_rot_job;
    logic signed [CWD-1:0] w_xs, w_ys, w_atan;
    logic signed [rsnh_pkg::TRIG_W-1:0] w_c, w_s;

    assign w_accept  = i_start && !o_busy;
    assign w_special = (i_ray_angle[13:0] == 14'd0);
    assign w_direct  = (i_operation == rsnh_pkg::OP_STORE) || w_special;
    assign w_flip    = i_ray_angle[15] ^ i_ray_angle[14];
    assign w_phase   = {i_ray_angle, 16'h0000} + (w_flip ? 32'h8000_0000 : 32'h0);

    always_comb begin
        w_in_job.op    = rsnh_pkg::t_op'(i_operation);
        w_in_job.slot  = i_wall_slot;
        w_in_job.ax    = i_end_ax;
        w_in_job.ay    = i_end_ay;
        w_in_job.bx    = i_end_bx;
        w_in_job.by    = i_end_by;
        w_in_job.upper = ~i_ray_angle[15];
        w_in_job.dir_c = '0;
        w_in_job.dir_s = '0;
        case (i_ray_angle[15:14])
            2'd0: w_in_job.dir_c = T_POS;
            2'd1: w_in_job.dir_s = T_POS;
            2'd2: w_in_job.dir_c = T_NEG;
            2'd3: w_in_job.dir_s = T_NEG;
            default: w_in_job.dir_c = '0;
        endcase
    end

    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_atan = $signed({2'b00, rsnh_pkg::atan_step(r_i)});

    assign w_c = rsnh_pkg::round_clamp(r_x);
    assign w_s = rsnh_pkg::round_clamp(r_y);

    always_comb begin
        w_rot_job       = r_job;
        w_rot_job.dir_c = r_flip ? -w_c : w_c;
        w_rot_job.dir_s = r_flip ? -w_s : w_s;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rsnh_pkg::F_IDLE: begin
                if (w_accept && !w_direct) n_state = rsnh_pkg::F_ROT;
            end
            rsnh_pkg::F_ROT: begin
                if (r_i == 5'(rsnh_pkg::CORDIC_STEPS - 1)) n_state = rsnh_pkg::F_PUSH;
            end
            rsnh_pkg::F_PUSH: begin
                if (!i_q_status.full) n_state = rsnh_pkg::F_IDLE;
            end
            default: n_state = rsnh_pkg::F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_push = 1'b0;
        o_job  = w_in_job;
        case (r_state)
            rsnh_pkg::F_IDLE: begin
                o_push = w_accept && w_direct;
            end
            rsnh_pkg::F_PUSH: begin
                o_push = !i_q_status.full;
                o_job  = w_rot_job;
            end
            default: o_push = 1'b0;
        endcase
    end

    assign o_busy = (r_state != rsnh_pkg::F_IDLE) || i_q_status.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsnh_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rsnh_pkg::F_IDLE && w_accept && !w_direct) begin
            r_job  <= w_in_job;
            r_x    <= rsnh_pkg::CORDIC_X0;
            r_y    <= '0;
            r_z    <= CWD'($signed(w_phase));
            r_i    <= '0;
            r_flip <= w_flip;
        end else if (r_state == rsnh_pkg::F_ROT) begin
            if (r_z >= 0) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_atan;
            end
            r_i <= r_i + 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== sv/rsnh_back.sv =====
`default_nettype none
// Back: wall table and the per-wall intersection sequencer.
module rsnh_back #(
    parameter int MAX_WALLS = rsnh_pkg::MAX_WALLS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire rsnh_pkg::t_q_status                    i_q_status,
    input  wire rsnh_pkg::t_job                         i_job,
    output logic                                        o_pop,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0]    i_player_x,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0]    i_player_y,
    input  wire logic [rsnh_pkg::COORD_W-1:0]           i_render_radius,
    input  wire logic [6:0]                             i_wall_count,
    output logic                                        o_valid,
    output logic                                        o_any_crossing,
    output logic                                        o_near_hit,
    output logic [5:0]                                  o_hit_wall,
    output logic [rsnh_pkg::COORD_W-1:0]                o_hit_distance,
    output logic signed [rsnh_pkg::COORD_W-1:0]         o_hit_x,
    output logic signed [rsnh_pkg::COORD_W-1:0]         o_hit_y
);
    `include "ray_segment_nearest_hit_defines.svh"

    localparam int AW  = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int WCW = $clog2(MAX_WALLS + 1);
    localparam int NCW = (WCW > 7) ? WCW : 7;
    localparam int CRW = rsnh_pkg::COORD_W;
    localparam int SW  = rsnh_pkg::SQ_W;
    localparam int NW  = rsnh_pkg::NUM_W;
    localparam logic signed [NW-1:0] FAR_POS = 64'sd1073741824;
    localparam logic signed [NW-1:0] FAR_NEG = -64'sd1073741824;

    rsnh_pkg::t_bstate r_state, n_state;

    logic [4*CRW-1:0] r_mem [MAX_WALLS];
    logic [4*CRW-1:0] r_rd;

    rsnh_pkg::t_job r_job;
    logic [WCW-1:0] r_w, r_n;

    logic signed [rsnh_pkg::DIFF_W-1:0]  r_ax, r_ay, r_dx, r_dy;
    logic signed [rsnh_pkg::DEN_W-1:0]   r_p0, r_p1, r_den;
    logic signed [rsnh_pkg::CROSS_W-1:0] r_p2, r_p3, r_cross;
    logic signed [NW-1:0] r_numc, r_nums, r_xr, r_yr, r_hx, r_hy;
    logic signed [SW-1:0] r_sqx, r_sqy;
    logic [SW-1:0]        r_sv, r_sr, r_sbit;

    logic           r_any, r_near;
    logic [5:0]     r_best_wall;
    logic [CRW-1:0] r_best;
    logic signed [CRW-1:0] r_bx, r_by;

    logic signed [CRW-1:0] w_x1, w_y1, w_x2, w_y2;
    logic signed [CRW-1:0] w_xmin, w_xmax, w_ymin, w_ymax;
    logic signed [15:0]    w_cos, w_sin;
    logic signed [16:0]    w_negc, w_negs;
    logic signed [66:0]    w_numc, w_nums;
    logic signed [25:0]    w_xr26, w_yr26;
    logic [SW-1:0]         w_rb;
    logic [NCW-1:0]        w_wc_ext;
    logic [WCW-1:0]        w_n;
    logic [31:0]           w_slot32, w_w32;
    logic                  w_slot_ok, w_far, w_pass, w_advance;

    logic                  w_div_start, w_div_busy, w_div_done;
    logic signed [NW-1:0]  w_div_num, w_div_q;

    assign w_x1 = $signed(r_rd[4*CRW-1:3*CRW]);
    assign w_y1 = $signed(r_rd[3*CRW-1:2*CRW]);
    assign w_x2 = $signed(r_rd[2*CRW-1:CRW]);
    assign w_y2 = $signed(r_rd[CRW-1:0]);
    assign w_xmin = (w_x1 < w_x2) ? w_x1 : w_x2;
    assign w_xmax = (w_x1 > w_x2) ? w_x1 : w_x2;
    assign w_ymin = (w_y1 < w_y2) ? w_y1 : w_y2;
    assign w_ymax = (w_y1 > w_y2) ? w_y1 : w_y2;

    assign w_cos  = r_job.dir_c;
    assign w_sin  = r_job.dir_s;
    assign w_negc = 17'sd0 - 17'(w_cos);
    assign w_negs = 17'sd0 - 17'(w_sin);
    assign w_numc = 67'(w_negc) * 67'(r_cross);
    assign w_nums = 67'(w_negs) * 67'(r_cross);

    assign w_xr26 = $signed(r_xr[25:0]);
    assign w_yr26 = $signed(r_yr[25:0]);
    assign w_rb   = r_sr + r_sbit;

    // walls searched: min(wall_count, MAX_WALLS)
    assign w_wc_ext = NCW'(i_wall_count);
    assign w_n = (w_wc_ext < NCW'(MAX_WALLS)) ? w_wc_ext[WCW-1:0] : WCW'(MAX_WALLS);

    assign w_slot32  = {26'd0, i_job.slot};
    assign w_slot_ok = w_slot32 < 32'(MAX_WALLS);
    assign w_w32     = 32'(r_w);

    assign w_far  = (w_div_q >= FAR_POS) || (w_div_q <= FAR_NEG);
    assign w_pass = (r_hx >= NW'(w_xmin)) && (r_hx <= NW'(w_xmax)) &&
                    (r_hy >= NW'(w_ymin)) && (r_hy <= NW'(w_ymax)) &&
                    (r_job.upper ? (r_yr >= 64'sd0) : (r_yr <= 64'sd0));

    rsnh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_div_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rsnh_pkg::B_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = (i_job.op == rsnh_pkg::OP_STORE) ?
                              rsnh_pkg::B_RESULT : rsnh_pkg::B_NEXT;
                end
            end
            rsnh_pkg::B_NEXT: begin
                n_state = (r_w == r_n) ? rsnh_pkg::B_RESULT : rsnh_pkg::B_READ;
            end
            rsnh_pkg::B_READ:   n_state = rsnh_pkg::B_PROD;
            rsnh_pkg::B_PROD:   n_state = rsnh_pkg::B_SUM;
            rsnh_pkg::B_SUM:    n_state = rsnh_pkg::B_DTEST;
            rsnh_pkg::B_DTEST: begin
                n_state = (r_den == '0) ? rsnh_pkg::B_NEXT : rsnh_pkg::B_DIVQ;
            end
            rsnh_pkg::B_DIVQ: begin
                if (w_div_done) n_state = w_far ? rsnh_pkg::B_NEXT : rsnh_pkg::B_MULC;
            end
            rsnh_pkg::B_MULC:   n_state = rsnh_pkg::B_STARTX;
            rsnh_pkg::B_STARTX: n_state = rsnh_pkg::B_DIVX;
            rsnh_pkg::B_DIVX: begin
                if (w_div_done) n_state = rsnh_pkg::B_STARTY;
            end
            rsnh_pkg::B_STARTY: n_state = rsnh_pkg::B_DIVY;
            rsnh_pkg::B_DIVY: begin
                if (w_div_done) n_state = rsnh_pkg::B_POINT;
            end
            rsnh_pkg::B_POINT:  n_state = rsnh_pkg::B_CHECK;
            rsnh_pkg::B_CHECK: begin
                n_state = w_pass ? rsnh_pkg::B_SQADD : rsnh_pkg::B_NEXT;
            end
            rsnh_pkg::B_SQADD:  n_state = rsnh_pkg::B_SQRT;
            rsnh_pkg::B_SQRT: begin
                if (r_sbit == '0) n_state = rsnh_pkg::B_CMP;
            end
            rsnh_pkg::B_CMP:    n_state = rsnh_pkg::B_NEXT;
            rsnh_pkg::B_RESULT: n_state = rsnh_pkg::B_IDLE;
            default:            n_state = rsnh_pkg::B_IDLE;
        endcase
    end

    // outputs and strobes
    always_comb begin
        o_pop       = 1'b0;
        o_valid     = 1'b0;
        w_div_start = 1'b0;
        w_div_num   = NW'(r_cross);
        w_advance   = 1'b0;
        case (r_state)
            rsnh_pkg::B_IDLE:   o_pop = !i_q_status.empty;
            rsnh_pkg::B_DTEST: begin
                w_div_start = (r_den != '0);
                w_advance   = (r_den == '0);
            end
            rsnh_pkg::B_DIVQ:   w_advance = w_div_done && w_far;
            rsnh_pkg::B_STARTX: begin
                w_div_start = 1'b1;
                w_div_num   = r_numc;
            end
            rsnh_pkg::B_STARTY: begin
                w_div_start = 1'b1;
                w_div_num   = r_nums;
            end
            rsnh_pkg::B_CHECK:  w_advance = !w_pass;
            rsnh_pkg::B_CMP:    w_advance = 1'b1;
            rsnh_pkg::B_RESULT: o_valid = 1'b1;
            default:            o_valid = 1'b0;
        endcase
    end

    assign o_any_crossing = r_any;
    assign o_near_hit     = r_near;
    assign o_hit_wall     = r_best_wall;
    assign o_hit_distance = r_best;
    assign o_hit_x        = r_bx;
    assign o_hit_y        = r_by;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsnh_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // wall table
    always_ff @(posedge i_clk) begin
        if (o_pop && i_job.op == rsnh_pkg::OP_STORE && w_slot_ok) begin
            r_mem[w_slot32[AW-1:0]] <= {i_job.ax, i_job.ay, i_job.bx, i_job.by};
        end
        if (r_state == rsnh_pkg::B_NEXT) begin
            r_rd <= r_mem[r_w[AW-1:0]];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_w <= r_w + 1'b1;
        end
        case (r_state)
            rsnh_pkg::B_IDLE: begin
                if (o_pop) begin
                    r_job       <= i_job;
                    r_w         <= '0;
                    r_n         <= w_n;
                    r_any       <= 1'b0;
                    r_near      <= 1'b0;
                    r_best_wall <= '0;
                    r_bx        <= '0;
                    r_by        <= '0;
                    r_best      <= (i_job.op == rsnh_pkg::OP_STORE) ? '0 : i_render_radius;
                end
            end
            rsnh_pkg::B_READ: begin
                r_ax <= rsnh_pkg::DIFF_W'(w_x1) - rsnh_pkg::DIFF_W'(i_player_x);
                r_ay <= rsnh_pkg::DIFF_W'(w_y1) - rsnh_pkg::DIFF_W'(i_player_y);
                r_dx <= rsnh_pkg::DIFF_W'(w_x2) - rsnh_pkg::DIFF_W'(w_x1);
                r_dy <= rsnh_pkg::DIFF_W'(w_y2) - rsnh_pkg::DIFF_W'(w_y1);
            end
            rsnh_pkg::B_PROD: begin
                r_p0 <= rsnh_pkg::DEN_W'(r_dx) * rsnh_pkg::DEN_W'(w_sin);
                r_p1 <= rsnh_pkg::DEN_W'(r_dy) * rsnh_pkg::DEN_W'(w_cos);
                r_p2 <= rsnh_pkg::CROSS_W'(r_ax) * rsnh_pkg::CROSS_W'(r_dy);
                r_p3 <= rsnh_pkg::CROSS_W'(r_ay) * rsnh_pkg::CROSS_W'(r_dx);
            end
            rsnh_pkg::B_SUM: begin
                r_den   <= r_p0 - r_p1;
                r_cross <= r_p2 - r_p3;
            end
            rsnh_pkg::B_MULC: begin
                r_numc <= w_numc[NW-1:0];
                r_nums <= w_nums[NW-1:0];
            end
            rsnh_pkg::B_DIVX: begin
                if (w_div_done) r_xr <= w_div_q;
            end
            rsnh_pkg::B_DIVY: begin
                if (w_div_done) r_yr <= w_div_q;
            end
            rsnh_pkg::B_POINT: begin
                r_hx <= NW'(i_player_x) + r_xr;
                r_hy <= NW'(i_player_y) + r_yr;
            end
            rsnh_pkg::B_CHECK: begin
                r_sqx <= SW'(w_xr26) * SW'(w_xr26);
                r_sqy <= SW'(w_yr26) * SW'(w_yr26);
            end
            rsnh_pkg::B_SQADD: begin
                r_sv   <= $unsigned(r_sqx + r_sqy);
                r_sr   <= '0;
                r_sbit <= SW'(1) << (SW - 2);
            end
            rsnh_pkg::B_SQRT: begin
                if (r_sbit != '0) begin
                    if (r_sv >= w_rb) begin
                        r_sv <= r_sv - w_rb;
                        r_sr <= (r_sr >> 1) + r_sbit;
                    end else begin
                        r_sr <= r_sr >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                end
            end
            rsnh_pkg::B_CMP: begin
                r_any <= 1'b1;
                if (r_sr < SW'(r_best)) begin
                    r_best      <= r_sr[CRW-1:0];
                    r_best_wall <= w_w32[5:0];
                    r_bx        <= r_hx[CRW-1:0];
                    r_by        <= r_hy[CRW-1:0];
                    r_near      <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    `RSNH_ASSERT_NEXT(a_result_one_cycle, i_clk, i_rst_n, r_state == rsnh_pkg::B_RESULT,
        r_state == rsnh_pkg::B_IDLE, "result strobe held past one cycle")
    `RSNH_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, o_pop, !i_q_status.empty,
        "pop from empty queue")
    `RSNH_ASSERT_NOW(a_div_free, i_clk, i_rst_n, w_div_start, !w_div_busy,
        "divider started while busy")
    `RSNH_ASSERT_NOW(a_store_zero, i_clk, i_rst_n,
        (r_state == rsnh_pkg::B_RESULT) && (r_job.op == rsnh_pkg::OP_STORE),
        !r_any && !r_near && (r_best == '0) && (r_bx == '0), "store word not zero")
    `RSNH_ASSERT_NOW(a_near_any, i_clk, i_rst_n, r_state == rsnh_pkg::B_RESULT,
        r_any || !r_near, "near hit without crossing")

endmodule
`default_nettype wire

// ===== sv/ray_segment_nearest_hit.sv =====
`default_nettype none
// Channel   Direction  Handshake            Word
// -------   ---------  -------------------  ---------------------------------------
// item      in         start & !busy        operation, wall_slot, end_*, ray_angle
// result    out        o_valid strobe       any_crossing, near_hit, hit_wall,
//                                           hit_distance, hit_x, hit_y
// config    in         cfg_valid&cfg_ready  cfg_index, cfg_data (ready always high)
//
// A store word's result follows once it has passed the queue and the back has popped it.
// A cast word runs 20 CORDIC rotations in the front and then a push, which waits while
// the queue is full (quarter turns skip the rotations); the back then walks each searched
// wall, stopping early if parallel, too far, or failing the box or side test; three
// divides and a 26-step square root serve a wall that counts. Reset idles both halves, table kept.
// The receiver cannot stall; busy is raised while the front works a cast or the two-word job queue is full.
module ray_segment_nearest_hit #(
    parameter int MAX_WALLS = rsnh_pkg::MAX_WALLS_DEF,
    parameter int FRAC_BITS = rsnh_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // item channel
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic                                   i_operation,
    input  wire logic [5:0]                             i_wall_slot,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0]    i_end_ax,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0]    i_end_ay,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0]    i_end_bx,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0]    i_end_by,
    input  wire logic [15:0]                            i_ray_angle,
    // result channel
    output logic                                        o_valid,
    output logic                                        o_any_crossing,
    output logic                                        o_near_hit,
    output logic [5:0]                                  o_hit_wall,
    output logic [rsnh_pkg::COORD_W-1:0]                o_hit_distance,
    output logic signed [rsnh_pkg::COORD_W-1:0]         o_hit_x,
    output logic signed [rsnh_pkg::COORD_W-1:0]         o_hit_y,
    // config channel
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [1:0]                             i_cfg_index,
    input  wire logic [rsnh_pkg::COORD_W-1:0]           i_cfg_data
);
    // render radius resets to 10.0 in the chosen fixed-point format
    localparam logic [rsnh_pkg::COORD_W-1:0] RR_RESET =
        rsnh_pkg::COORD_W'(64'd10 << FRAC_BITS);

    logic signed [rsnh_pkg::COORD_W-1:0] r_player_x, r_player_y;
    logic [rsnh_pkg::COORD_W-1:0]        r_render_radius;
    logic [6:0]                          r_wall_count;

    rsnh_pkg::t_q_status w_q_status;
    rsnh_pkg::t_job      w_push_job, w_head_job;
    logic                w_push, w_pop;

    // config registers; the user must send writes only while the block is idle; the block has no check for this
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_player_x      <= '0;
            r_player_y      <= '0;
            r_render_radius <= RR_RESET;
            r_wall_count    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rsnh_pkg::CFG_PLAYER_X:      r_player_x      <= $signed(i_cfg_data);
                rsnh_pkg::CFG_PLAYER_Y:      r_player_y      <= $signed(i_cfg_data);
                rsnh_pkg::CFG_RENDER_RADIUS: r_render_radius <= i_cfg_data;
                rsnh_pkg::CFG_WALL_COUNT:    r_wall_count    <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // front: accepts words, runs CORDIC for casts off the quarter turns
    rsnh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_operation (i_operation),
        .i_wall_slot (i_wall_slot),
        .i_end_ax    (i_end_ax),
        .i_end_ay    (i_end_ay),
        .i_end_bx    (i_end_bx),
        .i_end_by    (i_end_by),
        .i_ray_angle (i_ray_angle),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    // job queue keeps store/cast order into the back
    rsnh_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_job    (w_head_job),
        .o_status (w_q_status)
    );

    // back: table writes and the wall search
    rsnh_back #(
        .MAX_WALLS (MAX_WALLS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_status      (w_q_status),
        .i_job           (w_head_job),
        .o_pop           (w_pop),
        .i_player_x      (r_player_x),
        .i_player_y      (r_player_y),
        .i_render_radius (r_render_radius),
        .i_wall_count    (r_wall_count),
        .o_valid         (o_valid),
        .o_any_crossing  (o_any_crossing),
        .o_near_hit      (o_near_hit),
        .o_hit_wall      (o_hit_wall),
        .o_hit_distance  (o_hit_distance),
        .o_hit_x         (o_hit_x),
        .o_hit_y         (o_hit_y)
    );

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // Run limit in cycles; even an all-cast run at 64 walls stays well inside it.
    localparam longint RUN_LIMIT = 64'd60_000_000;
    localparam int     N_WALLS   = 64;

    typedef struct {
        rsnh_pkg::t_op op;
        logic [5:0]  slot;
        logic [23:0] ax;
        logic [23:0] ay;
        logic [23:0] bx;
        logic [23:0] by;
        logic [15:0] angle;
    } t_ray_word;

    typedef struct {
        logic        any_crossing;
        logic        near_hit;
        logic [5:0]  wall;
        logic [23:0] dist_q;
        logic [23:0] x;
        logic [23:0] y;
    } t_hit_word;

    // DUT ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_operation = 1'b0;
    logic [5:0]  i_wall_slot = '0;
    logic [23:0] i_end_ax = '0;
    logic [23:0] i_end_ay = '0;
    logic [23:0] i_end_bx = '0;
    logic [23:0] i_end_by = '0;
    logic [15:0] i_ray_angle = '0;
    logic        o_valid;
    logic        o_any_crossing;
    logic        o_near_hit;
    logic [5:0]  o_hit_wall;
    logic [23:0] o_hit_distance;
    logic [23:0] o_hit_x;
    logic [23:0] o_hit_y;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    ray_segment_nearest_hit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_wall_slot    (i_wall_slot),
        .i_end_ax       (i_end_ax),
        .i_end_ay       (i_end_ay),
        .i_end_bx       (i_end_bx),
        .i_end_by       (i_end_by),
        .i_ray_angle    (i_ray_angle),
        .o_valid        (o_valid),
        .o_any_crossing (o_any_crossing),
        .o_near_hit     (o_near_hit),
        .o_hit_wall     (o_hit_wall),
        .o_hit_distance (o_hit_distance),
        .o_hit_x        (o_hit_x),
        .o_hit_y        (o_hit_y),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: shadow wall table and registers
    // ------------------------------------------------------------------
    longint          wall_x1 [N_WALLS];
    longint          wall_y1 [N_WALLS];
    longint          wall_x2 [N_WALLS];
    longint          wall_y2 [N_WALLS];
    longint          eye_x = 0;
    longint          eye_y = 0;
    longint unsigned radius_q = 64'd40960;
    longint unsigned walls_searched = 0;

    // arctan(2^-i), 32-bit full turn
    longint atan_tab [20] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304
    };

    t_hit_word pending_hits [$];
    int        mismatches = 0;
    longint    cycle_count = 0;

    function automatic longint sx24(input logic [23:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint floor_div(input longint num, input longint den);
        longint q;
        q = num / den;
        if (num % den != 0 && ((num < 0) != (den < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic longint trig_clamp(input longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    // Unit direction in Q2.14: exact on quarter turns, CORDIC otherwise.
    function automatic void ray_direction(input logic [15:0] ang,
                                          output longint c, output longint s);
        logic [31:0] phase;
        longint      x, y, z, nx;
        logic        flip;
        x = 652032874;
        y = 0;
        if (ang[13:0] == 14'd0) begin
            c = (ang[15:14] == 2'd0) ? 16384 : (ang[15:14] == 2'd2) ? -16384 : 0;
            s = (ang[15:14] == 2'd1) ? 16384 : (ang[15:14] == 2'd3) ? -16384 : 0;
            return;
        end
        phase = {ang, 16'h0000};
        flip = ang[15] ^ ang[14];
        if (flip) phase = phase + 32'h8000_0000;
        z = longint'($signed(phase));
        for (int i = 0; i < 20; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_tab[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_tab[i];
            end
            x = nx;
        end
        x = trig_clamp((x + 32768) >>> 16);
        y = trig_clamp((y + 32768) >>> 16);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Applies one accepted word to the shadow state and returns its result.
    function automatic t_hit_word predict_nearest_hit(input t_ray_word w);
        t_hit_word       h;
        longint          c, s, bx, by, x1, y1, x2, y2, ax, ay, dx, dy;
        longint          den, crs, q, r, xr, yr, px, py;
        longint unsigned best, cand_dist, n;
        logic            upper;
        h = '{default: '0};
        if (w.op == rsnh_pkg::OP_STORE) begin
            wall_x1[w.slot] = sx24(w.ax);
            wall_y1[w.slot] = sx24(w.ay);
            wall_x2[w.slot] = sx24(w.bx);
            wall_y2[w.slot] = sx24(w.by);
            return h;
        end
        upper = ~w.angle[15];
        ray_direction(w.angle, c, s);
        best = radius_q;
        bx = 0;
        by = 0;
        n = (walls_searched < N_WALLS) ? walls_searched : N_WALLS;
        for (int k = 0; k < n; k++) begin
            x1 = wall_x1[k]; y1 = wall_y1[k];
            x2 = wall_x2[k]; y2 = wall_y2[k];
            ax = x1 - eye_x; ay = y1 - eye_y;
            dx = x2 - x1;    dy = y2 - y1;
            den = dx * s - dy * c;
            if (den == 0) continue;   // parallel ray or point segment
            crs = ax * dy - ay * dx;
            q = floor_div(crs, den);
            if (q >= (64'sd1 <<< 30) || q <= -(64'sd1 <<< 30)) continue;
            r = crs - q * den;
            xr = (-c) * q + floor_div((-c) * r, den);
            yr = (-s) * q + floor_div((-s) * r, den);
            px = eye_x + xr;
            py = eye_y + yr;
            if (px < ((x1 < x2) ? x1 : x2) || px > ((x1 > x2) ? x1 : x2)) continue;
            if (py < ((y1 < y2) ? y1 : y2) || py > ((y1 > y2) ? y1 : y2)) continue;
            if (upper ? (yr < 0) : (yr > 0)) continue;
            h.any_crossing = 1'b1;
            cand_dist = int_sqrt(longint'(xr * xr) + longint'(yr * yr));
            if (cand_dist < best) begin
                best = cand_dist;
                h.wall = k[5:0];
                bx = px;
                by = py;
                h.near_hit = 1'b1;
            end
        end
        h.dist_q = best[23:0];
        h.x = bx[23:0];
        h.y = by[23:0];
        return h;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: compares each strobe against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_hit_word e;
        if (i_rst_n && o_valid) begin
            if (pending_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word at cycle %0d", cycle_count);
            end else begin
                e = pending_hits.pop_front();
                if (o_any_crossing !== e.any_crossing || o_near_hit !== e.near_hit ||
                    o_hit_wall !== e.wall || o_hit_distance !== e.dist_q ||
                    o_hit_x !== e.x || o_hit_y !== e.y) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch cyc %0d exp any=%0b near=%0b wall=%0d ",
                                  "d=%h x=%h y=%h got any=%0b near=%0b wall=%0d ",
                                  "d=%h x=%h y=%h"},
                                 cycle_count, e.any_crossing, e.near_hit, e.wall,
                                 e.dist_q, e.x, e.y, o_any_crossing, o_near_hit,
                                 o_hit_wall, o_hit_distance, o_hit_x, o_hit_y);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks (always entered and left at a rising edge)
    // ------------------------------------------------------------------
    task automatic send_word(input t_ray_word w, input int idle_pct);
        start       <= 1'b1;
        i_operation <= w.op;
        i_wall_slot <= w.slot;
        i_end_ax    <= w.ax;
        i_end_ay    <= w.ay;
        i_end_bx    <= w.bx;
        i_end_by    <= w.by;
        i_ray_angle <= w.angle;
        do @(posedge i_clk); while (busy);
        pending_hits.push_back(predict_nearest_hit(w));
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Drop start and let every outstanding word drain before touching registers.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input rsnh_pkg::t_cfg_idx idx, input logic [23:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            rsnh_pkg::CFG_PLAYER_X:      eye_x = sx24(val);
            rsnh_pkg::CFG_PLAYER_Y:      eye_y = sx24(val);
            rsnh_pkg::CFG_RENDER_RADIUS: radius_q = val;
            rsnh_pkg::CFG_WALL_COUNT:    walls_searched = val[6:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_ray_word store_word(input logic [5:0] slot,
                                             input longint ax, input longint ay,
                                             input longint bx, input longint by);
        t_ray_word w;
        w.op = rsnh_pkg::OP_STORE;
        w.slot = slot;
        w.ax = ax[23:0];
        w.ay = ay[23:0];
        w.bx = bx[23:0];
        w.by = by[23:0];
        w.angle = 16'($urandom);
        return w;
    endfunction

    function automatic t_ray_word cast_word(input logic [15:0] ang);
        t_ray_word w;
        w.op = rsnh_pkg::OP_CAST;
        w.slot = 6'($urandom);
        w.ax = 24'($urandom);
        w.ay = 24'($urandom);
        w.bx = 24'($urandom);
        w.by = 24'($urandom);
        w.angle = ang;
        return w;
    endfunction

    function automatic longint near_ofs();
        return longint'($urandom_range(0, 98304)) - 49152;   // +-12.0
    endfunction

    // Random wall around the current origin; some special shapes mixed in.
    function automatic t_ray_word random_wall(input logic [5:0] slot);
        longint ax, ay, bx, by;
        int     kind;
        kind = $urandom_range(99);
        ax = eye_x + near_ofs(); ay = eye_y + near_ofs();
        bx = eye_x + near_ofs(); by = eye_y + near_ofs();
        if (kind < 10) bx = ax;                         // vertical
        else if (kind < 20) by = ay;                    // horizontal
        else if (kind < 25) begin bx = ax; by = ay; end // point
        else if (kind < 35) begin                       // anywhere
            ax = $urandom; ay = $urandom; bx = $urandom; by = $urandom;
        end
        return store_word(slot, ax, ay, bx, by);
    endfunction

    function automatic logic [15:0] random_angle();
        if ($urandom_range(9) == 0) return {2'($urandom_range(3)), 14'd0};
        return 16'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // empty search at reset settings
        send_word(cast_word(16'd0), 0);
        send_word(store_word(6'd0, 3 << 12, -(2 << 12), 3 << 12, 2 << 12), 0); // vertical
        send_word(store_word(6'd1, -(3 << 12), 4 << 12, 3 << 12, 4 << 12), 0); // horizontal
        send_word(store_word(6'd2, 3 << 12, 3 << 12, 3 << 12, 3 << 12), 0);    // point
        send_word(store_word(6'd3, 1 << 12, 0, 5 << 12, 0), 0);               // along x axis
        send_word(store_word(6'd4, -8388608, -8388608, 8388607, 8388607), 0);
        send_word(store_word(6'd5, 20 << 12, -(9 << 12), 20 << 12, 9 << 12), 0);
        send_word(store_word(6'd6, 3 << 12, -(2 << 12), 3 << 12, 2 << 12), 0); // tie with 0
        send_word(store_word(6'd63, 8388607, -8388608, -8388608, 8388607), 0);
        wait_idle();
        write_reg(rsnh_pkg::CFG_WALL_COUNT, 24'd7);
        send_word(cast_word(16'd0), 0);
        send_word(cast_word(16'd16384), 0);   // vertical ray
        send_word(cast_word(16'd32768), 0);
        send_word(cast_word(16'd49152), 0);
        send_word(cast_word(16'd8192), 0);
        send_word(cast_word(16'd65535), 0);
        send_word(cast_word(16'd1), 0);
        send_word(cast_word(16'd16385), 0);
        send_word(cast_word(16'd40960), 0);
        wait_idle();
        write_reg(rsnh_pkg::CFG_RENDER_RADIUS, 24'hFF_FFFF);  // far wall now counts as near
        send_word(cast_word(16'd0), 0);
        send_word(cast_word(16'd24576), 0);
        wait_idle();
        write_reg(rsnh_pkg::CFG_RENDER_RADIUS, 24'd0);        // nothing can be near
        send_word(cast_word(16'd0), 0);
        wait_idle();
    endtask

    // Every slot written once so that any wall count reads defined entries.
    task automatic test_fill_table();
        write_reg(rsnh_pkg::CFG_PLAYER_X, 24'd0);
        write_reg(rsnh_pkg::CFG_PLAYER_Y, 24'd0);
        for (int k = 0; k < N_WALLS; k++)
            send_word(random_wall(k[5:0]), 19);
        wait_idle();
    endtask

    task automatic random_config();
        logic [23:0] r;
        if ($urandom_range(4) == 0) write_reg(rsnh_pkg::CFG_PLAYER_X, 24'($urandom));
        else write_reg(rsnh_pkg::CFG_PLAYER_X, 24'(near_ofs() + near_ofs()));
        if ($urandom_range(4) == 0) write_reg(rsnh_pkg::CFG_PLAYER_Y, 24'($urandom));
        else write_reg(rsnh_pkg::CFG_PLAYER_Y, 24'(near_ofs() + near_ofs()));
        case ($urandom_range(9))
            0: r = 24'd0;
            1: r = 24'hFF_FFFF;
            default: r = 24'($urandom_range(0, 81920));
        endcase
        write_reg(rsnh_pkg::CFG_RENDER_RADIUS, r);
        write_reg(rsnh_pkg::CFG_WALL_COUNT, 24'($urandom_range(0, 8)));
    endtask

    task automatic test_random_traffic(input int idle_pct, input int n_items);
        int done;
        logic [5:0] slot;
        done = 0;
        while (done < n_items) begin
            random_config();
            for (int k = 0; k < 40 && done < n_items; k++) begin
                if ($urandom_range(99) < 45) begin
                    if (walls_searched != 0 && $urandom_range(1))
                        slot = 6'($urandom_range(0, int'(walls_searched) - 1));
                    else
                        slot = 6'($urandom);
                    send_word(random_wall(slot), idle_pct);
                end else begin
                    send_word(cast_word(random_angle()), idle_pct);
                end
                done++;
            end
            wait_idle();
        end
    endtask

    // Full table and a count past the table size.
    task automatic test_wall_count_extremes();
        write_reg(rsnh_pkg::CFG_PLAYER_X, 24'h7F_FFFF);
        write_reg(rsnh_pkg::CFG_PLAYER_Y, 24'h80_0000);
        write_reg(rsnh_pkg::CFG_RENDER_RADIUS, 24'hFF_FFFF);
        write_reg(rsnh_pkg::CFG_WALL_COUNT, 24'd64);
        send_word(cast_word(random_angle()), 0);
        send_word(cast_word(16'd49152), 0);
        wait_idle();
        write_reg(rsnh_pkg::CFG_PLAYER_X, 24'd0);
        write_reg(rsnh_pkg::CFG_PLAYER_Y, 24'd0);
        write_reg(rsnh_pkg::CFG_WALL_COUNT, 24'd127);
        send_word(cast_word(random_angle()), 19);
        send_word(cast_word(16'd0), 0);
        wait_idle();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_table();
        test_random_traffic(19, 400);
        test_random_traffic(62, 400);
        test_random_traffic(0, 400);
        test_wall_count_extremes();
        wait_idle();
        repeat (50) @(posedge i_clk);
        if (pending_hits.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== ray_segment_nearest_hit.f =====
+incdir+sv
sv/rsnh_pkg.sv
sv/rsnh_div.sv
sv/rsnh_queue.sv
sv/rsnh_front.sv
sv/rsnh_back.sv
sv/ray_segment_nearest_hit.sv
tb/sv/testbench.sv
